@@ rtl/ced_pkg.sv @@
// Shared types, constants and decode functions for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none
package ced_pkg;

  localparam int TABLE_ENTRIES = 12;
  localparam int KNOWN_ENTRIES = 12;
  localparam int LOOKUP_N = (TABLE_ENTRIES < KNOWN_ENTRIES) ? TABLE_ENTRIES : KNOWN_ENTRIES;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X = 8'h78;

  localparam logic [7:0] ESC_KEY [KNOWN_ENTRIES] = '{
    8'h61, 8'h62, 8'h66, 8'h72, 8'h6E, 8'h74, 8'h76, 8'h27, 8'h22, 8'h3F, 8'h5C, 8'h30
  };
  localparam logic [7:0] ESC_VAL [KNOWN_ENTRIES] = '{
    8'h07, 8'h08, 8'h0C, 8'h0D, 8'h0A, 8'h09, 8'h0B, 8'h27, 8'h22, 8'h3F, 8'h5C, 8'h00
  };

  // decoded bytes of one input item, lowest byte first
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
  } group_t;

  typedef struct packed {
    logic [2:0] k;
    logic [7:0] val;
  } dec_t;

  typedef struct packed {
    group_t          grp;
    logic [2:0][7:0] pend;
    logic [1:0]      pcnt;
  } step_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if ((c >= 8'h30) && (c <= 8'h39)) t = c - 8'h30;
    else if ((c >= 8'h61) && (c <= 8'h66)) t = c - 8'h57;
    else t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic digit_ok(input logic [7:0] c, input logic hex);
    return hex ? is_hex(c) : is_oct(c);
  endfunction

  // one escape resolution; k == 0 means wait for more bytes
  function automatic dec_t decode_one(input logic [3:0][7:0] b, input logic [2:0] n,
                                      input logic fin);
    dec_t d;
    logic hex;
    logic wait_more;
    logic match;
    logic hit;
    d.k = 3'd1;
    d.val = BSLASH;
    hex = (b[1] == CHAR_X);
    wait_more = 1'b0;
    match = 1'b0;
    hit = 1'b0;
    if (b[0] != BSLASH) begin
      d.val = b[0];
    end else if (n < 3'd2) begin
      if (!fin) d.k = 3'd0;
    end else begin
      if (is_oct(b[1]) || hex) begin
        if (n < 3'd3) wait_more = !fin;
        else if (digit_ok(b[2], hex)) begin
          if (n < 3'd4) wait_more = !fin;
          else match = digit_ok(b[3], hex);
        end
      end
      if (wait_more) begin
        d.k = 3'd0;
      end else if (match) begin
        d.k = 3'd4;
        if (hex) d.val = {hex_val(b[2]), hex_val(b[3])};
        else d.val = {b[1][1:0], b[2][2:0], b[3][2:0]};
      end else begin
        for (int i = 0; i < LOOKUP_N; i++) begin
          if (!hit && (b[1] == ESC_KEY[i])) begin
            hit = 1'b1;
            d.k = 3'd2;
            d.val = ESC_VAL[i];
          end
        end
      end
    end
    return d;
  endfunction

  function automatic step_t decode_step(input logic [2:0][7:0] pend, input logic [1:0] pcnt,
                                        input logic [7:0] c, input logic fin);
    step_t s;
    logic [3:0][7:0] b;
    logic [2:0] n;
    logic stop;
    dec_t d;
    s = '0;
    b = '0;
    for (int i = 0; i < 3; i++) b[i] = pend[i];
    b[pcnt] = c;
    n = {1'b0, pcnt} + 3'd1;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!stop && (n != 3'd0)) begin
        d = decode_one(b, n, fin);
        if (d.k == 3'd0) begin
          stop = 1'b1;
        end else begin
          s.grp.data[s.grp.cnt[1:0]] = d.val;
          s.grp.cnt = s.grp.cnt + 3'd1;
          case (d.k)
            3'd1:    b = {8'h00, b[3:1]};
            3'd2:    b = {16'h0000, b[3:2]};
            default: b = '0;
          endcase
          n = n - d.k;
        end
      end
    end
    s.grp.last = fin;
    s.pend = b[2:0];
    s.pcnt = fin ? 2'd0 : n[1:0];
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/c_escape_sequence_decoder.sv @@
// Top level of the C string escape sequence decoder.
// Accepts one source byte per cycle whenever the four-group queue has room and
// emits decoded bytes at one per cycle while out_tready is high; an input item
// that resolves k bytes (k from 0 to 4) keeps the output side busy until all k
// are sent, so the input side stalls only when the output serializer falls a
// full queue behind. Escapes are resolved in the same cycle the byte is taken;
// up to three lookahead bytes are held and flushed on the item marked last.
`timescale 1ns / 1ps
`default_nettype none
module c_escape_sequence_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_char
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast
);

  logic            q_full;
  logic            push;
  ced_pkg::group_t push_grp;
  logic            pop;
  logic            head_valid;
  ced_pkg::group_t head;

  ced_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  ced_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_grp   (push_grp),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ced_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/ced_front.sv @@
// Front end: accepts source bytes, holds lookahead and resolves escapes into byte groups.
`timescale 1ns / 1ps
`default_nettype none
module ced_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_last,
  input  wire logic        q_full,
  output logic             push,
  output ced_pkg::group_t  push_grp
);

  logic [2:0][7:0] pend_r;
  logic [1:0]      pcnt_r;
  ced_pkg::step_t  res;
  logic            accept;

  always_comb begin
    res = ced_pkg::decode_step(pend_r, pcnt_r, in_char, in_last);
    in_ready = !q_full;
    accept = in_valid && in_ready;
    push = accept && (res.grp.cnt != 3'd0);
    push_grp = res.grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
    end else if (accept) begin
      pcnt_r <= res.pcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend_r <= res.pend;
  end

endmodule
`default_nettype wire

@@ rtl/ced_queue.sv @@
// Short queue of decoded byte groups between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module ced_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ced_pkg::group_t push_grp,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output ced_pkg::group_t      head
);

  ced_pkg::group_t                mem [ced_pkg::QDEPTH];
  logic [ced_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [ced_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [ced_pkg::QCNT_W-1:0]     count_r;
  logic [ced_pkg::QCNT_W-1:0]     count_nxt;
  logic                           do_pop;

  always_comb begin
    full = (count_r == ced_pkg::QCNT_W'(ced_pkg::QDEPTH));
    head_valid = (count_r != '0);
    head = mem[rd_ptr_r];
    do_pop = pop && head_valid;
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + ced_pkg::QCNT_W'(1);
    else if (!push && do_pop) count_nxt = count_r - ced_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + ced_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + ced_pkg::QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_grp;
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ced_pkg::QCNT_W'(ced_pkg::QDEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");
`endif

endmodule
`default_nettype wire

@@ rtl/ced_back.sv @@
// Back end: serializes each queued byte group onto the output stream.
`timescale 1ns / 1ps
`default_nettype none
module ced_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire ced_pkg::group_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last
);

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       at_end;

  always_comb begin
    at_end = ({1'b0, idx_r} == (head.cnt - 3'd1));
    out_valid = head_valid;
    out_char = head.data[idx_r];
    out_last = head.last && at_end;
    pop = out_valid && out_ready && at_end;
    idx_nxt = idx_r;
    if (out_valid && out_ready) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ((head.cnt != 3'd0) && (head.cnt <= 3'd4)))
    else $error("empty or oversized group at queue head");
  a_idx_inside: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head.cnt))
    else $error("byte index past group end");
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (idx_r == 2'd0))
    else $error("index left over with empty queue");
`endif

endmodule
`default_nettype wire
